[rtl/qpht_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// qpht_pkg: shared definitions for the quadratic probe hash table
// Slot marks, status and operation codes, load limit constants and the
// controller state type.
// ---------------------------------------------------------------------------
package qpht_pkg;

   localparam int TABLE_SIZE_DEF = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 8;

   localparam int MARK_BITS  = 2;
   localparam int SLOT_BITS  = 6;
   localparam int LIMIT_BITS = 4;

   localparam logic [MARK_BITS-1:0] MARK_EMPTY   = 2'd0;
   localparam logic [MARK_BITS-1:0] MARK_LIVE    = 2'd1;
   localparam logic [MARK_BITS-1:0] MARK_DELETED = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_FIND   = 2'd1;
   localparam logic [1:0] FUNC_ERASE  = 2'd2;

   localparam int                    LOAD_SCALE = 10;
   localparam logic [LIMIT_BITS-1:0] LOAD_RESET = 4'd7;

   // key bits folded into the home remainder per cycle (non power of two size)
   localparam int HASH_DIGIT = 4;

   typedef enum logic [2:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_HASH,
      CTL_PROBE,
      CTL_DONE
   } state_type;

endpackage
`default_nettype wire

[rtl/qpht_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// qpht_ram: generic single write, single read synchronous RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module qpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/quadratic_probe_hash_table_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// quadratic_probe_hash_table_unit: open addressing key/value table
// Insert, find and erase on a fixed size table with quadratic probing.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one operation (func, key, value); rsp_* returns one result
//    (status, found_value, slot_index) per operation, in order.
//  - csr_* writes the load limit in tenths; write it only while idle.
//  - Slot mark, key and data share one RAM with a registered read.
//    Probe addresses are issued back to back, each read word evaluated
//    while the next probe is issued.
//  - With a power of two size the walk starts from the low key bits; other
//    sizes first fold the key into the home slot remainder. The next
//    request is taken the cycle after the result is loaded. Inserts refused
//    at the load limit and unused codes skip the walk and answer directly.
//  - After reset a clearing pass marks every slot empty with req_ready low;
//    csr writes are taken during it.
//  - A stalled receiver holds the result in the output register; the unit
//    finishes the next operation and then waits until that register frees.
// ---------------------------------------------------------------------------
module quadratic_probe_hash_table_unit
   import qpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [1:0]            rsp_status,
   output logic      [VALUE_BITS-1:0] rsp_found_value,
   output logic      [SLOT_BITS-1:0]  rsp_slot_index,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LIMIT_BITS-1:0] csr_load_limit_tenths
);

   localparam int  AW         = $clog2(TABLE_SIZE);
   localparam int  CW         = $clog2(TABLE_SIZE + 1);
   localparam int  LW         = CW + 4;
   localparam int  MW         = MARK_BITS + KEY_BITS + VALUE_BITS;
   localparam bit  IS_POW2    = (TABLE_SIZE == (1 << AW));
   localparam int  HASH_STEPS = (KEY_BITS + HASH_DIGIT - 1) / HASH_DIGIT;
   localparam int  PADW       = HASH_STEPS * HASH_DIGIT;
   localparam int  HCW        = $clog2(HASH_STEPS);

   // controller and datapath registers
   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [1:0]            func_ff, func_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [PADW-1:0]       hash_sh_ff, hash_sh_in;
   logic [AW-1:0]         hash_rem_ff, hash_rem_in;
   logic [HCW-1:0]        hash_cnt_ff, hash_cnt_in;
   logic [AW-1:0]         probe_addr_ff, probe_addr_in;
   logic [AW-1:0]         probe_inc_ff, probe_inc_in;
   logic [CW-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  pend_last_ff, pend_last_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_fval_ff, res_fval_in;
   logic [AW-1:0]         res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_fval_ff, rsp_fval_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;

   // RAM port
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [MW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [MW-1:0] ram_rd_data;

   // decode of the word read back
   logic [MARK_BITS-1:0]  rd_mark;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  rd_live, rd_key_eq;
   logic                  eval, decided, finish;
   logic                  accept, load_full, rsp_free, rsp_load, op_known;
   logic [AW-1:0]         hash_next;
   logic [AW-1:0]         probe_next, inc_next;
   logic [AW+1+SLOT_BITS-1:0] slot_wide;

   qpht_ram #(
      .WIDTH (MW),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_mark   = ram_rd_data[MW-1 -: MARK_BITS];
   assign rd_key    = ram_rd_data[VALUE_BITS +: KEY_BITS];
   assign rd_val    = ram_rd_data[VALUE_BITS-1:0];
   assign rd_live   = (rd_mark == MARK_LIVE);
   assign rd_key_eq = (rd_key == key_ff);

   assign req_ready = (state_ff == CTL_IDLE);
   assign csr_ready = !reset;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == CTL_DONE) && rsp_free;
   assign op_known  = (req_func == FUNC_INSERT) || (req_func == FUNC_FIND) ||
                      (req_func == FUNC_ERASE);

   // floor(10 * count / size) >= limit  <=>  10 * count >= limit * size
   assign load_full = (LW'(count_ff) * LW'(LOAD_SCALE)) >=
                      (LW'(limit_ff) * LW'(TABLE_SIZE));

   // the read data of the probe issued last cycle
   assign eval = (state_ff == CTL_PROBE) && pend_ff;

   always_comb begin
      if (func_ff == FUNC_INSERT) begin
         decided = !rd_live || rd_key_eq;
      end else begin
         decided = (rd_mark == MARK_EMPTY) || (rd_live && rd_key_eq);
      end
   end

   assign finish = eval && (decided || pend_last_ff);

   // home remainder: fold HASH_DIGIT key bits per cycle, MSB first
   always_comb begin
      logic [AW:0]   t;
      logic [AW-1:0] r;
      r = hash_rem_ff;
      for (int j = 0; j < HASH_DIGIT; j++) begin
         t = {r, hash_sh_ff[PADW-1-j]};
         if (t >= (AW+1)'(TABLE_SIZE)) begin
            t = t - (AW+1)'(TABLE_SIZE);
         end
         r = t[AW-1:0];
      end
      hash_next = r;
   end

   // next probe: offset grows by 2i+1, both kept below the table size
   always_comb begin
      logic [AW:0] sum;
      logic [AW:0] inc;
      sum = {1'b0, probe_addr_ff} + {1'b0, probe_inc_ff};
      if (sum >= (AW+1)'(TABLE_SIZE)) begin
         sum = sum - (AW+1)'(TABLE_SIZE);
      end
      inc = {1'b0, probe_inc_ff} + (AW+1)'(2);
      if (inc >= (AW+1)'(TABLE_SIZE)) begin
         inc = inc - (AW+1)'(TABLE_SIZE);
      end
      probe_next = sum[AW-1:0];
      inc_next   = inc[AW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_CLEAR: begin
            if (clr_addr_ff == AW'(TABLE_SIZE - 1)) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_IDLE: begin
            if (accept) begin
               if (!op_known || ((req_func == FUNC_INSERT) && load_full)) begin
                  state_in = CTL_DONE;
               end else if (IS_POW2) begin
                  state_in = CTL_PROBE;
               end else begin
                  state_in = CTL_HASH;
               end
            end
         end
         CTL_HASH: begin
            if (hash_cnt_ff == HCW'(HASH_STEPS - 1)) begin
               state_in = CTL_PROBE;
            end
         end
         CTL_PROBE: begin
            if (finish) begin
               state_in = CTL_DONE;
            end
         end
         CTL_DONE: begin
            if (rsp_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_CLEAR;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      hash_sh_in    = hash_sh_ff;
      hash_rem_in   = hash_rem_ff;
      hash_cnt_in   = hash_cnt_ff;
      probe_addr_in = probe_addr_ff;
      probe_inc_in  = probe_inc_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_last_in  = pend_last_ff;
      count_in      = count_ff;
      limit_in      = csr_valid ? csr_load_limit_tenths : limit_ff;
      res_status_in = res_status_ff;
      res_fval_in   = res_fval_ff;
      res_slot_in   = res_slot_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pend_addr_ff;
      ram_wr_data   = {MARK_LIVE, key_ff, value_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = probe_addr_ff;

      unique case (state_ff)
         CTL_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = {MARK_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         CTL_IDLE: begin
            if (accept) begin
               func_in       = req_func;
               key_in        = req_key;
               value_in      = req_value;
               hash_sh_in    = PADW'(req_key);
               hash_rem_in   = '0;
               hash_cnt_in   = '0;
               probe_addr_in = AW'(req_key);
               probe_inc_in  = AW'(1);
               issue_cnt_in  = '0;
               res_fval_in   = '0;
               res_slot_in   = '0;
               res_status_in = op_known ? STAT_FULL : STAT_MISS;
            end
         end
         CTL_HASH: begin
            hash_sh_in    = hash_sh_ff << HASH_DIGIT;
            hash_rem_in   = hash_next;
            hash_cnt_in   = hash_cnt_ff + HCW'(1);
            probe_addr_in = hash_next;
         end
         CTL_PROBE: begin
            if (finish) begin
               res_fval_in = '0;
               res_slot_in = '0;
               if (func_ff == FUNC_INSERT) begin
                  if (!rd_live) begin
                     ram_wr_en     = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_status_in = STAT_OK;
                     res_slot_in   = pend_addr_ff;
                  end else if (rd_key_eq) begin
                     res_status_in = STAT_DUP;
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end else if (rd_live && rd_key_eq) begin
                  res_status_in = STAT_OK;
                  res_slot_in   = pend_addr_ff;
                  if (func_ff == FUNC_FIND) begin
                     res_fval_in = rd_val;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {MARK_DELETED, rd_key, rd_val};
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end else begin
                  res_status_in = STAT_MISS;
               end
            end else if (issue_cnt_ff != CW'(TABLE_SIZE)) begin
               // issue the next probe while the last one is evaluated
               ram_rd_en     = 1'b1;
               pend_in       = 1'b1;
               pend_addr_in  = probe_addr_ff;
               pend_last_in  = (issue_cnt_ff == CW'(TABLE_SIZE - 1));
               probe_addr_in = probe_next;
               probe_inc_in  = inc_next;
               issue_cnt_in  = issue_cnt_ff + CW'(1);
            end
         end
         CTL_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign slot_wide = {{(SLOT_BITS + 1){1'b0}}, res_slot_ff};

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_fval_in   = res_fval_ff;
         rsp_slot_in   = slot_wide[SLOT_BITS-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= LOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      hash_sh_ff    <= hash_sh_in;
      hash_rem_ff   <= hash_rem_in;
      hash_cnt_ff   <= hash_cnt_in;
      probe_addr_ff <= probe_addr_in;
      probe_inc_ff  <= probe_inc_in;
      issue_cnt_ff  <= issue_cnt_in;
      pend_addr_ff  <= pend_addr_in;
      pend_last_ff  <= pend_last_in;
      res_status_ff <= res_status_in;
      res_fval_ff   <= res_fval_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // table writes only come from the clearing pass or a finished probe walk
   a_wr_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == CTL_CLEAR) || finish)
      else $error("slot RAM written outside clearing or probe finish");

   // a successful insert bumps the live count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (finish && ram_wr_en && (func_ff == FUNC_INSERT)) |=>
         (count_ff == $past(count_ff) + CW'(1)))
      else $error("live count not incremented on insert");

   // no request is taken while the table is being cleared
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   // a result is only loaded while the output register is free
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_status_ff) && $stable(rsp_slot_ff))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

[verif/quadratic_probe_hash_table_unit_tb.sv]
// ---------------------------------------------------------------------------
// quadratic_probe_hash_table_unit_tb: self-checking bench for the hash table
// Drives insert, find, erase and the unused code into the table and checks
// every response, field by field, against a local copy of the slot array.
// The bench runs directed cases for the limits and the probe cap, then
// clustered random traffic over several load limits. Both sides stall at
// random, but for the last two load limits of the sweep.
// ---------------------------------------------------------------------------
module quadratic_probe_hash_table_unit_tb;
   import qpht_pkg::*;

   localparam int         TBL_SIZE    = TABLE_SIZE_DEF;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         ITEMS_PER_LIMIT = 175;

   typedef struct packed {
      logic [1:0]           status;
      logic [VALUE_BITS_DEF-1:0] found_value;
      logic [SLOT_BITS-1:0] slot_index;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_func  = '0;
   logic [KEY_BITS_DEF-1:0]   req_key   = '0;
   logic [VALUE_BITS_DEF-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_status;
   logic [VALUE_BITS_DEF-1:0] rsp_found_value;
   logic [SLOT_BITS-1:0]      rsp_slot_index;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [LIMIT_BITS-1:0]     csr_load_limit_tenths = '0;

   // shadow of the table
   logic [MARK_BITS-1:0]      shadow_mark [TBL_SIZE];
   logic [KEY_BITS_DEF-1:0]   shadow_key  [TBL_SIZE];
   logic [VALUE_BITS_DEF-1:0] shadow_data [TBL_SIZE];
   int                        shadow_live;
   int                        shadow_limit;

   table_result_type          awaited_results [$];
   logic [KEY_BITS_DEF-1:0]   inserted_keys [$];

   int send_idle_pct = 15;
   int recv_idle_pct = 84;
   int ops_sent      = 0;
   int rsp_checked   = 0;
   int mismatch_count = 0;
   int cycle_count   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   quadratic_probe_hash_table_unit #(
      .TABLE_SIZE (TBL_SIZE),
      .KEY_BITS   (KEY_BITS_DEF),
      .VALUE_BITS (VALUE_BITS_DEF)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_key               (req_key),
      .req_value             (req_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_found_value       (rsp_found_value),
      .rsp_slot_index        (rsp_slot_index),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_load_limit_tenths (csr_load_limit_tenths)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Applies one operation to the shadow table and returns its response.
   function automatic table_result_type table_predict(input logic [1:0] func,
                                                      input logic [KEY_BITS_DEF-1:0] key,
                                                      input logic [VALUE_BITS_DEF-1:0] value);
      table_result_type r;
      int               home;
      int               s;
      int               hit_slot;
      int               i;
      bit               done;
      r        = '{status: STAT_MISS, found_value: '0, slot_index: '0};
      home     = key % TBL_SIZE;
      done     = 1'b0;
      hit_slot = -1;
      if (func == FUNC_INSERT) begin
         r.status = STAT_FULL;
         if (LOAD_SCALE * shadow_live / TBL_SIZE < shadow_limit) begin
            for (i = 0; i < TBL_SIZE && !done; i++) begin
               s = (home + i * i) % TBL_SIZE;
               if (shadow_mark[s] != MARK_LIVE) begin
                  shadow_mark[s] = MARK_LIVE;
                  shadow_key[s]  = key;
                  shadow_data[s] = value;
                  shadow_live++;
                  r.status     = STAT_OK;
                  r.slot_index = s[SLOT_BITS-1:0];
                  done         = 1'b1;
               end else if (shadow_key[s] == key) begin
                  r.status = STAT_DUP;
                  done     = 1'b1;
               end
            end
         end
      end else if (func == FUNC_FIND || func == FUNC_ERASE) begin
         // walk stops at an empty slot; deleted slots are passed over
         for (i = 0; i < TBL_SIZE && !done; i++) begin
            s = (home + i * i) % TBL_SIZE;
            if (shadow_mark[s] == MARK_EMPTY) begin
               done = 1'b1;
            end else if (shadow_mark[s] == MARK_LIVE && shadow_key[s] == key) begin
               hit_slot = s;
               done     = 1'b1;
            end
         end
         if (hit_slot >= 0) begin
            r.status     = STAT_OK;
            r.slot_index = hit_slot[SLOT_BITS-1:0];
            if (func == FUNC_FIND) begin
               r.found_value = shadow_data[hit_slot];
            end else begin
               shadow_mark[hit_slot] = MARK_DELETED;
               if (shadow_live > 0) shadow_live--;
            end
         end
      end
      return r;
   endfunction

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      table_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_checked++;
         status_seen[rsp_status]++;
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d value %0h slot %0d",
                        rsp_status, rsp_found_value, rsp_slot_index);
         end else begin
            exp_r = awaited_results.pop_front();
            if (rsp_status !== exp_r.status || rsp_found_value !== exp_r.found_value ||
                rsp_slot_index !== exp_r.slot_index) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at response %0d: expected %0d/%0h/%0d got %0d/%0h/%0d",
                           rsp_checked, exp_r.status, exp_r.found_value, exp_r.slot_index,
                           rsp_status, rsp_found_value, rsp_slot_index);
            end
         end
      end
   end

   task automatic send_op(input logic [1:0] func, input logic [KEY_BITS_DEF-1:0] key,
                          input logic [VALUE_BITS_DEF-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_results.push_back(table_predict(func, key, value));
      ops_sent++;
      if (func == FUNC_INSERT) begin
         inserted_keys.push_back(key);
         if (inserted_keys.size() > 48) void'(inserted_keys.pop_front());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_load_limit(input logic [LIMIT_BITS-1:0] limit);
      wait_idle();
      csr_valid             <= 1'b1;
      csr_load_limit_tenths <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      shadow_limit = limit;
   endtask

   // mostly clustered homes so probe chains get long
   function automatic logic [KEY_BITS_DEF-1:0] fresh_key();
      logic [KEY_BITS_DEF-1:0] k;
      k = $urandom;
      if ($urandom_range(2) != 0) k[5:0] = 6'($urandom_range(7) * 8);
      return k;
   endfunction

   task automatic test_basic_ops();
      send_op(FUNC_FIND, 32'h0, 8'h00);            // empty table
      send_op(FUNC_ERASE, 32'h0, 8'h00);
      send_op(FUNC_INSERT, 32'h0, 8'h00);
      send_op(FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF);
      send_op(FUNC_INSERT, 32'h0, 8'h55);          // duplicate
      send_op(FUNC_FIND, 32'hFFFF_FFFF, 8'h00);
      send_op(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      send_op(FUNC_ERASE, 32'h0, 8'h00);
      // equal key hidden behind a deleted slot is written again
      send_op(FUNC_INSERT, 32'h100, 8'h01);
      send_op(FUNC_INSERT, 32'h200, 8'h02);
      send_op(FUNC_ERASE, 32'h100, 8'h00);
      send_op(FUNC_INSERT, 32'h200, 8'h03);
      send_op(FUNC_FIND, 32'h200, 8'h00);
   endtask

   task automatic test_zero_limit();
      set_load_limit(4'd0);
      send_op(FUNC_INSERT, 32'h200, 8'hA5);        // full before the dup check
      send_op(FUNC_FIND, 32'h200, 8'h00);
   endtask

   task automatic test_probe_cap();
      int i;
      set_load_limit(4'd15);
      // home 5 reaches only a dozen slots under i*i probing
      for (i = 0; i < 13; i++)
         send_op(FUNC_INSERT, {26'($urandom), 6'd5}, 8'($urandom_range(255)));
      send_op(FUNC_FIND, {26'($urandom), 6'd5}, 8'h00);
   endtask

   task automatic test_random_traffic(input int n_items);
      int                      i;
      int                      pick;
      logic [1:0]              func;
      logic [KEY_BITS_DEF-1:0] key;
      for (i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) func = FUNC_INSERT;
         else if (pick < 75) func = FUNC_FIND;
         else if (pick < 95) func = FUNC_ERASE;
         else func = FUNC_UNUSED;
         key = fresh_key();
         if (func != FUNC_INSERT && inserted_keys.size() != 0 && $urandom_range(3) != 0)
            key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         send_op(func, key, 8'($urandom_range(255)));
      end
   endtask

   task automatic test_load_limit_sweep();
      logic [LIMIT_BITS-1:0] limits [6] = '{4'd7, 4'd1, 4'd10, 4'd15, 4'd3, 4'd12};
      int                    p;
      for (p = 0; p < 6; p++) begin
         set_load_limit(limits[p]);
         if (p < 2) begin
            send_idle_pct = 15;
            recv_idle_pct = 84;
         end else if (p < 4) begin
            send_idle_pct = 84;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         test_random_traffic(ITEMS_PER_LIMIT);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < TBL_SIZE; i++) begin
         shadow_mark[i] = MARK_EMPTY;
         shadow_key[i]  = '0;
         shadow_data[i] = '0;
      end
      shadow_live  = 0;
      shadow_limit = LOAD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_zero_limit();
      test_probe_cap();
      test_load_limit_sweep();

      wait_idle();
      repeat (70) @(posedge clock);
      $display("ran %0d operations over load limits 0 to 15 with stalls on both sides",
               ops_sent);
      $display("compared %0d responses: ok %0d, dup %0d, miss %0d, full %0d",
               rsp_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
